>>> rtl/tgarle_pkg.sv
// Shared types, constants and reset values for the TGA run-length pixel decoder.
package tgarle_pkg;

   typedef enum logic [1:0] {
      FMT_GREY8 = 2'd0,
      FMT_RGB555 = 2'd1,
      FMT_BGR24 = 2'd2,
      FMT_BGRA32 = 2'd3
   } pixel_format_type;

   typedef enum logic [1:0] {
      CSR_PIXEL_FORMAT = 2'd0,
      CSR_COMPRESSED = 2'd1,
      CSR_LINE_WIDTH = 2'd2,
      CSR_LINE_TOTAL = 2'd3
   } csr_index_type;

   localparam int CSR_DATA_W = 16;
   localparam int OUT_DATA_W = 40;
   localparam int QUEUE_DEPTH = 2;

   localparam pixel_format_type PIXEL_FORMAT_RST = FMT_BGR24;
   localparam logic COMPRESSED_RST = 1'b1;
   localparam logic [15:0] LINE_WIDTH_RST = 16'd640;
   localparam logic [15:0] LINE_TOTAL_RST = 16'd480;

   localparam logic [7:0] HDR_RUN_BIT = 8'h80;
   localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;

   typedef struct packed {
      pixel_format_type pixel_format;
      logic compressed;
      logic [15:0] line_width;
      logic [15:0] line_total;
   } cfg_type;

   typedef struct packed {
      logic [31:0] pixel_bytes;
      logic [7:0] repeat_count;
      logic end_of_line;
      logic end_of_image;
   } entry_type;

endpackage

>>> rtl/tgarle_front.sv
// Front end: packet header parsing, pixel byte assembly and line/image tracking.
module tgarle_front (
   input logic clock,
   input logic reset,
   input logic restart,
   input tgarle_pkg::cfg_type cfg,
   input logic accept,
   input logic [7:0] data_byte,
   output logic push,
   output tgarle_pkg::entry_type push_entry
);
   import tgarle_pkg::*;

   logic expect_header_ff, expect_header_in;
   logic run_packet_ff, run_packet_in;
   logic [7:0] packet_left_ff, packet_left_in;
   logic discarding_ff, discarding_in;
   logic [1:0] byte_position_ff, byte_position_in;
   logic [31:0] pixel_bytes_ff, pixel_bytes_in;
   logic [15:0] line_pixels_left_ff, line_pixels_left_in;
   logic [15:0] lines_left_ff, lines_left_in;

   logic [15:0] width_eff;
   logic [15:0] total_eff;

   assign width_eff = (cfg.line_width == 16'd0) ? 16'd1 : cfg.line_width;
   assign total_eff = (cfg.line_total == 16'd0) ? 16'd1 : cfg.line_total;

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_header_ff <= 1'b1;
         run_packet_ff <= 1'b0;
         packet_left_ff <= 8'd0;
         discarding_ff <= 1'b0;
         byte_position_ff <= 2'd0;
         line_pixels_left_ff <= LINE_WIDTH_RST;
         lines_left_ff <= LINE_TOTAL_RST;
      end else begin
         expect_header_ff <= expect_header_in;
         run_packet_ff <= run_packet_in;
         packet_left_ff <= packet_left_in;
         discarding_ff <= discarding_in;
         byte_position_ff <= byte_position_in;
         line_pixels_left_ff <= line_pixels_left_in;
         lines_left_ff <= lines_left_in;
      end
      pixel_bytes_ff <= pixel_bytes_in;
   end

   always_comb begin
      logic [31:0] pix_new;
      logic do_emit;
      logic raw_more;
      logic [7:0] rep_req;
      logic [7:0] rep_clip;
      logic [7:0] left_next;
      logic [15:0] pix_left_rem;
      logic [15:0] lines_rem;
      logic eol;
      logic eoi;

      expect_header_in = expect_header_ff;
      run_packet_in = run_packet_ff;
      packet_left_in = packet_left_ff;
      discarding_in = discarding_ff;
      byte_position_in = byte_position_ff;
      pixel_bytes_in = pixel_bytes_ff;
      line_pixels_left_in = line_pixels_left_ff;
      lines_left_in = lines_left_ff;

      pix_new = '0;
      do_emit = 1'b0;
      raw_more = 1'b0;
      rep_req = 8'd1;
      rep_clip = 8'd1;
      left_next = 8'd0;
      pix_left_rem = 16'd0;
      lines_rem = 16'd0;
      eol = 1'b0;
      eoi = 1'b0;

      if (accept) begin
         if (cfg.compressed && expect_header_ff) begin
            run_packet_in = |(data_byte & HDR_RUN_BIT);
            packet_left_in = (data_byte & HDR_COUNT_MASK) + 8'd1;
            expect_header_in = 1'b0;
            discarding_in = 1'b0;
            byte_position_in = 2'd0;
            pixel_bytes_in = '0;
         end else begin
            pix_new = (byte_position_ff == 2'd0) ? 32'd0 : pixel_bytes_ff;
            pix_new[{byte_position_ff, 3'b000} +: 8] = data_byte;
            pixel_bytes_in = pix_new;
            if (byte_position_ff < cfg.pixel_format) begin
               byte_position_in = byte_position_ff + 2'd1;
            end else begin
               byte_position_in = 2'd0;
               if (!cfg.compressed) begin
                  do_emit = 1'b1;
               end else if (run_packet_ff) begin
                  rep_req = packet_left_ff;
                  packet_left_in = 8'd0;
                  expect_header_in = 1'b1;
                  do_emit = 1'b1;
               end else begin
                  left_next = (packet_left_ff != 8'd0) ? packet_left_ff - 8'd1 : 8'd0;
                  packet_left_in = left_next;
                  if (left_next == 8'd0) begin
                     expect_header_in = 1'b1;
                  end
                  if (discarding_ff) begin
                     if (left_next == 8'd0) begin
                        discarding_in = 1'b0;
                     end
                  end else begin
                     do_emit = 1'b1;
                     raw_more = (left_next != 8'd0);
                  end
               end
            end
         end
      end

      if (do_emit) begin
         rep_clip = ({8'd0, rep_req} > line_pixels_left_ff) ? line_pixels_left_ff[7:0] : rep_req;
         pix_left_rem = line_pixels_left_ff - {8'd0, rep_clip};
         line_pixels_left_in = pix_left_rem;
         if (pix_left_rem == 16'd0) begin
            eol = 1'b1;
            lines_rem = (lines_left_ff != 16'd0) ? lines_left_ff - 16'd1 : 16'd0;
            lines_left_in = lines_rem;
            if (lines_rem == 16'd0) begin
               eoi = 1'b1;
            end else begin
               line_pixels_left_in = width_eff;
               if (raw_more) begin
                  discarding_in = 1'b1;
               end
            end
         end
      end

      if (eoi || restart) begin
         expect_header_in = 1'b1;
         run_packet_in = 1'b0;
         packet_left_in = 8'd0;
         discarding_in = 1'b0;
         byte_position_in = 2'd0;
         pixel_bytes_in = '0;
         line_pixels_left_in = width_eff;
         lines_left_in = total_eff;
      end

      push = do_emit;
      push_entry.pixel_bytes = pix_new;
      push_entry.repeat_count = rep_clip;
      push_entry.end_of_line = eol;
      push_entry.end_of_image = eoi;
   end

   a_rep_nonzero: assert property (@(posedge clock) disable iff (reset)
      push |-> push_entry.repeat_count != 8'd0)
      else $error("pixel pushed with a zero repeat count");

   a_line_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_pixels_left_ff != 16'd0)
      else $error("pixels left in line reached zero without a line change");

   a_eoi_has_eol: assert property (@(posedge clock) disable iff (reset)
      push && push_entry.end_of_image |-> push_entry.end_of_line)
      else $error("end of image flagged without end of line");

   a_restart_header: assert property (@(posedge clock) disable iff (reset)
      push && push_entry.end_of_image |=> expect_header_ff && byte_position_ff == 2'd0)
      else $error("decoder did not return to header state after end of image");

endmodule

>>> rtl/tgarle_queue.sv
// Short queue between the front end and the pixel conversion stage.
module tgarle_queue (
   input logic clock,
   input logic reset,
   input logic push,
   input tgarle_pkg::entry_type push_entry,
   input logic pop,
   output logic not_empty,
   output logic full,
   output tgarle_pkg::entry_type head
);
   import tgarle_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign not_empty = (count_ff != '0);
   assign full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head = mem_ff[rd_ptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue occupancy out of range");

endmodule

>>> rtl/tgarle_back.sv
// Back end: colour conversion of queued pixels into the registered result stage.
module tgarle_back (
   input logic clock,
   input logic reset,
   input tgarle_pkg::pixel_format_type pixel_format,
   input logic not_empty,
   input tgarle_pkg::entry_type head,
   output logic pop,
   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [tgarle_pkg::OUT_DATA_W-1:0] rsp_tdata,
   output logic rsp_tlast,
   output logic rsp_tuser
);
   import tgarle_pkg::*;

   logic valid_ff, valid_in;
   logic [OUT_DATA_W-1:0] data_ff, data_in;
   logic last_ff, last_in;
   logic user_ff, user_in;

   function automatic logic [31:0] convert(input pixel_format_type fmt,
                                           input logic [31:0] pb);
      logic [31:0] chans;
      chans = '0;
      unique case (fmt)
         FMT_GREY8: chans = {24'd0, pb[7:0]};
         FMT_RGB555: chans = {8'd0, pb[4:0], 3'b000, pb[9:5], 3'b000, pb[14:10], 3'b000};
         FMT_BGR24: chans = {8'd0, pb[7:0], pb[15:8], pb[23:16]};
         FMT_BGRA32: chans = {pb[31:24], pb[7:0], pb[15:8], pb[23:16]};
         default: chans = '0;
      endcase
      return chans;
   endfunction

   always_comb begin
      pop = not_empty && (!valid_ff || rsp_tready);
      valid_in = valid_ff;
      data_in = data_ff;
      last_in = last_ff;
      user_in = user_ff;
      if (pop) begin
         valid_in = 1'b1;
         data_in = {head.repeat_count, convert(pixel_format, head.pixel_bytes)};
         last_in = head.end_of_line;
         user_in = head.end_of_image;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      last_ff <= last_in;
      user_ff <= user_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = data_ff;
   assign rsp_tlast = last_ff;
   assign rsp_tuser = user_ff;

   a_load_on_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> valid_ff)
      else $error("result register not loaded after queue read");

   a_count_valid: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> data_ff[39:32] != 8'd0)
      else $error("result with a zero repeat count");

   a_eoi_eol: assert property (@(posedge clock) disable iff (reset)
      valid_ff && user_ff |-> last_ff)
      else $error("end of image shown without end of line");

endmodule

>>> rtl/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder with its configuration registers.
// Takes one byte per clock; req_tready falls only when the two-entry queue is full.
// The byte that completes a pixel is written into the queue, then loaded into the registered result stage.
// A pixel takes 1 to 4 bytes, plus one header byte per packet in compressed mode.
// Synchronous reset restores register defaults and starts a new image.
// Any configuration write also restarts the decoder at the head of an image.
module tga_rle_pixel_decoder (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   input logic [7:0] req_tdata,                       // data_byte
   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [tgarle_pkg::OUT_DATA_W-1:0] rsp_tdata, // chan0, chan1, chan2, chan3, repeat_count
   output logic rsp_tlast,                            // end_of_line
   output logic rsp_tuser,                            // end_of_image
   input logic csr_we,
   input logic [1:0] csr_index,
   input logic [tgarle_pkg::CSR_DATA_W-1:0] csr_data
);
   import tgarle_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic accept;
   logic push;
   entry_type push_entry;
   logic pop;
   logic not_empty;
   logic full;
   entry_type head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PIXEL_FORMAT: cfg_in.pixel_format = pixel_format_type'(csr_data[1:0]);
            CSR_COMPRESSED: cfg_in.compressed = csr_data[0];
            CSR_LINE_WIDTH: cfg_in.line_width = csr_data[15:0];
            CSR_LINE_TOTAL: cfg_in.line_total = csr_data[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_format <= PIXEL_FORMAT_RST;
         cfg_ff.compressed <= COMPRESSED_RST;
         cfg_ff.line_width <= LINE_WIDTH_RST;
         cfg_ff.line_total <= LINE_TOTAL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = !full;
   assign accept = req_tvalid && req_tready;

   tgarle_front u_front (
      .clock(clock),
      .reset(reset),
      .restart(csr_we),
      .cfg(cfg_in),
      .accept(accept),
      .data_byte(req_tdata),
      .push(push),
      .push_entry(push_entry)
   );

   tgarle_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_entry(push_entry),
      .pop(pop),
      .not_empty(not_empty),
      .full(full),
      .head(head)
   );

   tgarle_back u_back (
      .clock(clock),
      .reset(reset),
      .pixel_format(cfg_ff.pixel_format),
      .not_empty(not_empty),
      .head(head),
      .pop(pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

endmodule
